### rtl/cpc_pkg.sv
package cpc_pkg;

   localparam int unsigned SQRT_STEPS = 25;
   localparam int unsigned DIV_STEPS  = 15;

   // Side data that rides along with every pair through the pipe
   typedef struct packed {
      logic signed [23:0] ax;
      logic signed [23:0] ay;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic [22:0]        ra;
      logic [23:0]        rsum;
      logic signed [24:0] rvx;
      logic signed [24:0] rvy;
      logic [23:0]        dlen;
      logic               hit0;
   } ctx_type;

   // Digit-by-digit square root working set
   typedef struct packed {
      logic [49:0] rad;
      logic [26:0] rem;
      logic [24:0] root;
   } sqrt_type;

   // Restoring divider working set, two lanes sharing one divisor
   typedef struct packed {
      logic [40:0] rem_x;
      logic [40:0] rem_y;
      logic [40:0] dsh;
      logic [14:0] qx;
      logic [14:0] qy;
   } div_type;

   // Clamp to the 24 bit signed range
   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      logic signed [23:0] r;
      if (v > 28'sd8388607) begin
         r = 24'sh7fffff;
      end else if (v < -28'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

### rtl/cpc_sqrt_cell.sv
module cpc_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              vld_i,
   input  cpc_pkg::sqrt_type sq_i,
   input  cpc_pkg::ctx_type  ctx_i,
   output logic              vld_o,
   output cpc_pkg::sqrt_type sq_o,
   output cpc_pkg::ctx_type  ctx_o
);
   import cpc_pkg::*;

   logic     vld_ff;
   sqrt_type sq_ff, sq_in;
   ctx_type  ctx_ff;
   logic [26:0] rem_sh, trial;

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      rem_sh = {sq_i.rem[24:0], sq_i.rad[49:48]};
      trial  = {sq_i.root[24:0], 2'b01};
      sq_in.rad = {sq_i.rad[47:0], 2'b00};
      if (rem_sh >= trial) begin
         sq_in.rem  = rem_sh - trial;
         sq_in.root = {sq_i.root[23:0], 1'b1};
      end else begin
         sq_in.rem  = rem_sh;
         sq_in.root = {sq_i.root[23:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
      sq_ff  <= sq_in;
      ctx_ff <= ctx_i;
   end

   assign vld_o = vld_ff;
   assign sq_o  = sq_ff;
   assign ctx_o = ctx_ff;

endmodule

### rtl/cpc_div_cell.sv
module cpc_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             vld_i,
   input  cpc_pkg::div_type dv_i,
   input  cpc_pkg::ctx_type ctx_i,
   output logic             vld_o,
   output cpc_pkg::div_type dv_o,
   output cpc_pkg::ctx_type ctx_o
);
   import cpc_pkg::*;

   logic    vld_ff;
   div_type dv_ff, dv_in;
   ctx_type ctx_ff;
   logic    ge_x, ge_y;

   // Subtract the shifted divisor where it fits, one quotient bit per lane
   always_comb begin
      ge_x = dv_i.rem_x >= dv_i.dsh;
      ge_y = dv_i.rem_y >= dv_i.dsh;
      dv_in.rem_x = ge_x ? dv_i.rem_x - dv_i.dsh : dv_i.rem_x;
      dv_in.rem_y = ge_y ? dv_i.rem_y - dv_i.dsh : dv_i.rem_y;
      dv_in.dsh   = {1'b0, dv_i.dsh[40:1]};
      dv_in.qx    = {dv_i.qx[13:0], ge_x};
      dv_in.qy    = {dv_i.qy[13:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
      dv_ff  <= dv_in;
      ctx_ff <= ctx_i;
   end

   assign vld_o = vld_ff;
   assign dv_o  = dv_ff;
   assign ctx_o = ctx_ff;

endmodule

### rtl/circle_pair_contact_unit.sv
// Circle pair contact test. One pair is taken each cycle (busy stays low) and
// its result leaves the pipe on the rsp_ ports, held for one cycle and
// marked by rsp_valid; the receiver cannot stall, so results must be taken as
// they come. The pipe is made of the square-root chain (25 cells, one root
// bit each) and the normal divider chain (15 cells, one quotient bit each),
// plus three setup stages and three stages for normal, products and output.
module circle_pair_contact_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_center_a_x,
   input  logic signed [23:0] req_center_a_y,
   input  logic signed [23:0] req_center_b_x,
   input  logic signed [23:0] req_center_b_y,
   input  logic [22:0]        req_radius_a,
   input  logic [22:0]        req_radius_b,
   input  logic signed [23:0] req_vel_a_x,
   input  logic signed [23:0] req_vel_a_y,
   input  logic signed [23:0] req_vel_b_x,
   input  logic signed [23:0] req_vel_b_y,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [23:0]        rsp_depth,
   output logic signed [23:0] rsp_contact_x,
   output logic signed [23:0] rsp_contact_y,
   output logic signed [23:0] rsp_separating_velocity
);
   import cpc_pkg::*;

   // Stage 0: differences
   logic    s0_vld_ff;
   ctx_type s0_ctx_ff, s0_ctx_in;

   always_comb begin
      s0_ctx_in.ax   = req_center_a_x;
      s0_ctx_in.ay   = req_center_a_y;
      s0_ctx_in.dx   = {req_center_b_x[23], req_center_b_x} - {req_center_a_x[23], req_center_a_x};
      s0_ctx_in.dy   = {req_center_b_y[23], req_center_b_y} - {req_center_a_y[23], req_center_a_y};
      s0_ctx_in.ra   = req_radius_a;
      s0_ctx_in.rsum = {1'b0, req_radius_a} + {1'b0, req_radius_b};
      s0_ctx_in.rvx  = {req_vel_b_x[23], req_vel_b_x} - {req_vel_a_x[23], req_vel_a_x};
      s0_ctx_in.rvy  = {req_vel_b_y[23], req_vel_b_y} - {req_vel_a_y[23], req_vel_a_y};
      s0_ctx_in.dlen = '0;
      s0_ctx_in.hit0 = 1'b0;
   end

   // Stage 1: squares
   logic        s1_vld_ff;
   ctx_type     s1_ctx_ff;
   logic [24:0] mag_x, mag_y;
   logic [49:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [47:0] rs2_ff, rs2_in;

   always_comb begin
      mag_x  = s0_ctx_ff.dx[24] ? 25'(-s0_ctx_ff.dx) : 25'(s0_ctx_ff.dx);
      mag_y  = s0_ctx_ff.dy[24] ? 25'(-s0_ctx_ff.dy) : 25'(s0_ctx_ff.dy);
      sqx_in = mag_x * mag_x;
      sqy_in = mag_y * mag_y;
      rs2_in = s0_ctx_ff.rsum * s0_ctx_ff.rsum;
   end

   // Stage 2: squared distance and overlap test
   logic        s2_vld_ff;
   ctx_type     s2_ctx_ff, s2_ctx_in;
   logic [49:0] d2_ff, d2_in;

   always_comb begin
      d2_in          = sqx_ff + sqy_ff;
      s2_ctx_in      = s1_ctx_ff;
      s2_ctx_in.hit0 = (d2_in != '0) && (d2_in < {2'b00, rs2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
      s0_ctx_ff <= s0_ctx_in;
      s1_ctx_ff <= s0_ctx_ff;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      rs2_ff    <= rs2_in;
      s2_ctx_ff <= s2_ctx_in;
      d2_ff     <= d2_in;
   end

   // Square root chain
   logic     sq_vld [0:SQRT_STEPS];
   sqrt_type sq_dat [0:SQRT_STEPS];
   ctx_type  sq_ctx [0:SQRT_STEPS];

   assign sq_vld[0]      = s2_vld_ff;
   assign sq_dat[0].rad  = d2_ff;
   assign sq_dat[0].rem  = '0;
   assign sq_dat[0].root = '0;
   assign sq_ctx[0]      = s2_ctx_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      cpc_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .vld_i (sq_vld[i]),
         .sq_i  (sq_dat[i]),
         .ctx_i (sq_ctx[i]),
         .vld_o (sq_vld[i+1]),
         .sq_o  (sq_dat[i+1]),
         .ctx_o (sq_ctx[i+1])
      );
   end

   // Divider setup: numerator 2*|d|*2^14 + distance, divisor 2*distance
   logic        dv_vld [0:DIV_STEPS];
   div_type     dv_dat [0:DIV_STEPS];
   ctx_type     dv_ctx [0:DIV_STEPS];
   logic [23:0] dlen;
   logic [24:0] mag_dx, mag_dy;

   always_comb begin
      dlen   = sq_dat[SQRT_STEPS].root[23:0];
      mag_dx = sq_ctx[SQRT_STEPS].dx[24] ? 25'(-sq_ctx[SQRT_STEPS].dx)
                                         : 25'(sq_ctx[SQRT_STEPS].dx);
      mag_dy = sq_ctx[SQRT_STEPS].dy[24] ? 25'(-sq_ctx[SQRT_STEPS].dy)
                                         : 25'(sq_ctx[SQRT_STEPS].dy);
      dv_vld[0]       = sq_vld[SQRT_STEPS];
      dv_dat[0].rem_x = {1'b0, mag_dx, 15'b0} + {17'b0, dlen};
      dv_dat[0].rem_y = {1'b0, mag_dy, 15'b0} + {17'b0, dlen};
      dv_dat[0].dsh   = {2'b00, dlen, 15'b0};
      dv_dat[0].qx    = '0;
      dv_dat[0].qy    = '0;
      dv_ctx[0]       = sq_ctx[SQRT_STEPS];
      dv_ctx[0].dlen  = dlen;
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      cpc_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .vld_i (dv_vld[j]),
         .dv_i  (dv_dat[j]),
         .ctx_i (dv_ctx[j]),
         .vld_o (dv_vld[j+1]),
         .dv_o  (dv_dat[j+1]),
         .ctx_o (dv_ctx[j+1])
      );
   end

   // Stage N: signed normal
   logic               n_vld_ff;
   ctx_type            n_ctx_ff;
   logic signed [15:0] nx_ff, ny_ff, nx_in, ny_in;

   always_comb begin
      nx_in = dv_ctx[DIV_STEPS].dx[24] ? -$signed({1'b0, dv_dat[DIV_STEPS].qx})
                                       :  $signed({1'b0, dv_dat[DIV_STEPS].qx});
      ny_in = dv_ctx[DIV_STEPS].dy[24] ? -$signed({1'b0, dv_dat[DIV_STEPS].qy})
                                       :  $signed({1'b0, dv_dat[DIV_STEPS].qy});
   end

   // Stage M: products
   logic               m_vld_ff;
   ctx_type            m_ctx_ff;
   logic signed [15:0] m_nx_ff, m_ny_ff;
   logic signed [40:0] pvx_ff, pvy_ff, pvx_in, pvy_in;
   logic signed [39:0] pcx_ff, pcy_ff, pcx_in, pcy_in;

   always_comb begin
      pvx_in = n_ctx_ff.rvx * nx_ff;
      pvy_in = n_ctx_ff.rvy * ny_ff;
      pcx_in = nx_ff * $signed({1'b0, n_ctx_ff.ra});
      pcy_in = ny_ff * $signed({1'b0, n_ctx_ff.ra});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
      end else begin
         n_vld_ff <= dv_vld[DIV_STEPS];
         m_vld_ff <= n_vld_ff;
      end
      n_ctx_ff <= dv_ctx[DIV_STEPS];
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      m_ctx_ff <= n_ctx_ff;
      m_nx_ff  <= nx_ff;
      m_ny_ff  <= ny_ff;
      pvx_ff   <= pvx_in;
      pvy_ff   <= pvy_in;
      pcx_ff   <= pcx_in;
      pcy_ff   <= pcy_in;
   end

   // Final stage: floor and round, saturate, approach test
   logic signed [41:0] dot;
   logic signed [27:0] sep_w, cx_w, cy_w;
   logic signed [40:0] rcx, rcy;
   logic signed [23:0] sep;
   logic               hit;

   always_comb begin
      dot   = {pvx_ff[40], pvx_ff} + {pvy_ff[40], pvy_ff};
      sep_w = dot[41:14];
      sep   = sat24(sep_w);
      hit   = m_ctx_ff.hit0 && sep_w[27];
      rcx   = {pcx_ff[39], pcx_ff} + (pcx_ff[39] ? 41'sd8191 : 41'sd8192);
      rcy   = {pcy_ff[39], pcy_ff} + (pcy_ff[39] ? 41'sd8191 : 41'sd8192);
      cx_w  = {{4{m_ctx_ff.ax[23]}}, m_ctx_ff.ax} + {rcx[40], rcx[40:14]};
      cy_w  = {{4{m_ctx_ff.ay[23]}}, m_ctx_ff.ay} + {rcy[40], rcy[40:14]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= m_vld_ff;
      end
      rsp_hit <= hit;
      if (hit) begin
         rsp_normal_x            <= m_nx_ff;
         rsp_normal_y            <= m_ny_ff;
         rsp_depth               <= m_ctx_ff.rsum - m_ctx_ff.dlen;
         rsp_contact_x           <= sat24(cx_w);
         rsp_contact_y           <= sat24(cy_w);
         rsp_separating_velocity <= sep;
      end else begin
         rsp_normal_x            <= '0;
         rsp_normal_y            <= '0;
         rsp_depth               <= '0;
         rsp_contact_x           <= '0;
         rsp_contact_y           <= '0;
         rsp_separating_velocity <= '0;
      end
   end

   // Fully pipelined: never hold off a transfer
   assign busy = 1'b0;

endmodule

### rtl/cpc_checker.sv
module cpc_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_hit,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic [23:0]        rsp_depth,
   input logic signed [23:0] rsp_contact_x,
   input logic signed [23:0] rsp_contact_y,
   input logic signed [23:0] rsp_separating_velocity
);

   // A miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_normal_x == 0 && rsp_normal_y == 0 &&
         rsp_depth == 0 && rsp_contact_x == 0 && rsp_contact_y == 0 &&
         rsp_separating_velocity == 0)
      else $error("miss with nonzero fields");

   // A hit approaches and overlaps
   a_hit_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_separating_velocity[23] && rsp_depth != 0)
      else $error("hit without approach or overlap");

   // Normal components stay within one
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384
         && rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384)
      else $error("normal out of range");

   // The pipe never stalls a transfer
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

bind circle_pair_contact_unit cpc_checker u_cpc_checker (
   .clock                   (clock),
   .reset                   (reset),
   .busy                    (busy),
   .rsp_valid               (rsp_valid),
   .rsp_hit                 (rsp_hit),
   .rsp_normal_x            (rsp_normal_x),
   .rsp_normal_y            (rsp_normal_y),
   .rsp_depth               (rsp_depth),
   .rsp_contact_x           (rsp_contact_x),
   .rsp_contact_y           (rsp_contact_y),
   .rsp_separating_velocity (rsp_separating_velocity)
);

### tb/circle_pair_contact_unit_tb.sv
module circle_pair_contact_unit_tb;

   // One expected contact result
   typedef struct {
      logic               hit;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [23:0]        depth;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] sep;
   } contact_type;

   // Pair predictor and queue of expected contacts
   class contact_board;
      contact_type pending[$];
      int          errors;

      function automatic longint isqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return longint'(r);
      endfunction

      function automatic longint div_near(longint num, longint den);
         longint m;
         longint q;
         m = (num < 0) ? -num : num;
         q = (2 * m + den) / (2 * den);
         return (num < 0) ? -q : q;
      endfunction

      function automatic longint q14_near(longint x);
         longint m;
         longint q;
         m = (x < 0) ? -x : x;
         q = (m + 8192) >>> 14;
         return (x < 0) ? -q : q;
      endfunction

      function automatic longint clamp24(longint x);
         if (x > 8388607) return 8388607;
         if (x < -8388608) return -8388608;
         return x;
      endfunction

      // Predict the contact for one accepted pair
      function void note_pair(longint ax, longint ay, longint bx, longint by,
                              longint ra, longint rb, longint vax, longint vay,
                              longint vbx, longint vby);
         contact_type e;
         longint dx, dy, d2, rs, dlen, nx, ny, sp;
         e = '{hit: 0, nx: 0, ny: 0, depth: 0, cx: 0, cy: 0, sep: 0};
         dx = bx - ax;
         dy = by - ay;
         d2 = dx * dx + dy * dy;
         rs = ra + rb;
         if (d2 != 0 && d2 < rs * rs) begin
            dlen = isqrt(d2);
            nx = div_near(dx * 16384, dlen);
            ny = div_near(dy * 16384, dlen);
            // arithmetic shift is floor division
            sp = clamp24(((vbx - vax) * nx + (vby - vay) * ny) >>> 14);
            if (sp < 0) begin
               e.hit   = 1;
               e.nx    = nx[15:0];
               e.ny    = ny[15:0];
               e.depth = 24'(rs - dlen);
               e.cx    = 24'(clamp24(ax + q14_near(nx * ra)));
               e.cy    = 24'(clamp24(ay + q14_near(ny * ra)));
               e.sep   = sp[23:0];
            end
         end
         pending = {pending, e};
      endfunction

      // Compare one result against the oldest expectation
      function void check_contact(contact_type got);
         contact_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result hit=%0d", $time, got.hit);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.hit !== e.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.hit, got.hit);
            errors++;
         end
         if (got.nx !== e.nx) begin
            $display("%0t: normal_x exp %0d got %0d", $time, e.nx, got.nx);
            errors++;
         end
         if (got.ny !== e.ny) begin
            $display("%0t: normal_y exp %0d got %0d", $time, e.ny, got.ny);
            errors++;
         end
         if (got.depth !== e.depth) begin
            $display("%0t: depth exp %0d got %0d", $time, e.depth, got.depth);
            errors++;
         end
         if (got.cx !== e.cx) begin
            $display("%0t: contact_x exp %0d got %0d", $time, e.cx, got.cx);
            errors++;
         end
         if (got.cy !== e.cy) begin
            $display("%0t: contact_y exp %0d got %0d", $time, e.cy, got.cy);
            errors++;
         end
         if (got.sep !== e.sep) begin
            $display("%0t: separating_velocity exp %0d got %0d", $time, e.sep,
                     got.sep);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [23:0] req_center_a_x, req_center_a_y;
   logic signed [23:0] req_center_b_x, req_center_b_y;
   logic [22:0]        req_radius_a, req_radius_b;
   logic signed [23:0] req_vel_a_x, req_vel_a_y, req_vel_b_x, req_vel_b_y;
   logic               rsp_valid, rsp_hit;
   logic signed [15:0] rsp_normal_x, rsp_normal_y;
   logic [23:0]        rsp_depth;
   logic signed [23:0] rsp_contact_x, rsp_contact_y, rsp_separating_velocity;

   contact_board board;
   longint       cycles;

   circle_pair_contact_unit dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL circle_pair_contact_unit");
         $finish;
      end
   end

   // Take every result on the strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_contact('{hit: rsp_hit, nx: rsp_normal_x, ny: rsp_normal_y,
                               depth: rsp_depth, cx: rsp_contact_x,
                               cy: rsp_contact_y, sep: rsp_separating_velocity});
      end
   end

   // Drive one pair and hold it until the transfer
   task automatic send_pair(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
                            logic [23:0] by, logic [22:0] ra, logic [22:0] rb,
                            logic [23:0] vax, logic [23:0] vay, logic [23:0] vbx,
                            logic [23:0] vby, int gap);
      start          <= 1;
      req_center_a_x <= ax;
      req_center_a_y <= ay;
      req_center_b_x <= bx;
      req_center_b_y <= by;
      req_radius_a   <= ra;
      req_radius_b   <= rb;
      req_vel_a_x    <= vax;
      req_vel_a_y    <= vay;
      req_vel_b_x    <= vbx;
      req_vel_b_y    <= vby;
      do @(posedge clock); while (busy);
      board.note_pair(longint'($signed(ax)), longint'($signed(ay)),
                      longint'($signed(bx)), longint'($signed(by)),
                      longint'(ra), longint'(rb),
                      longint'($signed(vax)), longint'($signed(vay)),
                      longint'($signed(vbx)), longint'($signed(vby)));
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [23:0] rand24();
      return 24'($urandom);
   endfunction

   // Near pair: small offsets and radii so contacts are common
   task automatic send_close(int gap);
      logic signed [23:0] ax, ay;
      int                 span;
      span = ($urandom_range(0, 3) == 0) ? 2000000 : 40000;
      ax = rand24();
      ay = rand24();
      send_pair(ax, ay, 24'(ax + $signed(24'($urandom_range(0, 2 * span)) - span)),
                24'(ay + $signed(24'($urandom_range(0, 2 * span)) - span)),
                23'($urandom_range(0, span)), 23'($urandom_range(0, span)),
                rand24(), rand24(), rand24(), rand24(), gap);
   endtask

   initial begin
      int gap;
      board  = new();
      cycles = 0;
      reset  = 1;
      start  = 0;
      {req_center_a_x, req_center_a_y, req_center_b_x, req_center_b_y} = '0;
      {req_radius_a, req_radius_b} = '0;
      {req_vel_a_x, req_vel_a_y, req_vel_b_x, req_vel_b_y} = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: coincident centers, no overlap, separating, resting, extremes
      send_pair(100, 100, 100, 100, 5000, 5000, 0, 0, -4096, 0, 0);
      send_pair(0, 0, 40960, 0, 4096, 4096, 4096, 0, -4096, 0, 0);
      send_pair(0, 0, 4096, 0, 4096, 4096, -4096, 0, 4096, 0, 0);
      send_pair(0, 0, 4096, 0, 4096, 4096, 0, 0, 0, 0, 0);
      send_pair(0, 0, 4096, 0, 4096, 4096, 4096, 0, -4096, 0, 0);
      send_pair(0, 0, 0, -4096, 4096, 4096, 0, -4096, 0, 4096, 0);
      send_pair(0, 0, 3, 4, 3, 3, 1, 1, 0, 0, 1);
      send_pair(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 23'h7fffff,
                23'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 0);
      send_pair(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 23'h7fffff,
                23'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 0);
      send_pair(24'h7fff00, 0, 24'h7fffff, 0, 23'h7fffff, 0, 24'h7fffff, 0,
                24'h800000, 0, 0);
      send_pair(24'h800100, 0, 24'h800000, 0, 23'h7fffff, 0, 24'h800000, 0,
                24'h7fffff, 0, 0);
      send_pair(0, 0, 1, 0, 1, 1, 1, 0, 0, 0, 2);
      send_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      send_pair(rand24(), rand24(), rand24(), rand24(), 23'h7fffff, 23'h7fffff,
                rand24(), rand24(), rand24(), rand24(), 0);

      // Let everything drain before the random part
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);

      for (int i = 0; i < 1750; i++) begin
         gap = ((i / 200) % 2 == 0) ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 9) < 8) begin
            send_close(gap);
         end else begin
            send_pair(rand24(), rand24(), rand24(), rand24(), 23'($urandom),
                      23'($urandom), rand24(), rand24(), rand24(), rand24(), gap);
         end
         if (i == 900) begin
            start <= 0;
            while (board.pending.size() != 0) @(posedge clock);
         end
      end
      start <= 0;

      // Drain, then allow for the pipe latency
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS circle_pair_contact_unit");
      end else begin
         $display("FAIL circle_pair_contact_unit");
      end
      $finish;
   end

endmodule
